// File: rtl/core/dzr_pkg.sv
`default_nettype none
package dzr_pkg;

  localparam int COMPONENT_BITS_DEF = 24;

  localparam int MAG_W     = 24;
  localparam int ANG_W     = 16;
  localparam int THR_W     = 24;
  localparam int CFG_W     = 58;
  localparam int CFG_IDX_W = 3;
  localparam int NZONES    = 3;
  localparam int TIME_W    = 32;
  localparam int REACH_W   = 24;
  localparam int REACH2_W  = 48;
  localparam int LIM_W     = 17;
  localparam int DELAY_W   = 16;
  localparam int ACC_W     = 23;
  localparam int DIFF_W    = 24;
  localparam int CORDIC_N  = 16;
  localparam int SQRT_N    = 24;
  localparam int NMUL      = 11;
  localparam int SEL_W     = 4;
  localparam int STEP_W    = 4;
  localparam int OUT_W     = 48;
  localparam int USER_W    = 2;

  localparam logic [ACC_W-1:0] ANG_PI_FINE = ACC_W'(1048576);

  // zone setting fields
  localparam int ZS_LIM_LO   = 24;
  localparam int ZS_DELAY_LO = 41;
  localparam int ZS_EN       = 57;

  // result word bit positions
  localparam int OD_ANG_LO  = 24;
  localparam int OD_TRIP_LO = 40;

  typedef enum logic [1:0] {
    STS_DISABLED, STS_BELOW, STS_WRONG_DIR, STS_EVAL
  } status_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VTHR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTHR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE3     = 3'd6;

  // multiplier schedule
  localparam logic [SEL_W-1:0] MS_VR2   = 4'd0;
  localparam logic [SEL_W-1:0] MS_VI2   = 4'd1;
  localparam logic [SEL_W-1:0] MS_IR2   = 4'd2;
  localparam logic [SEL_W-1:0] MS_II2   = 4'd3;
  localparam logic [SEL_W-1:0] MS_DOTR  = 4'd4;
  localparam logic [SEL_W-1:0] MS_DOTI  = 4'd5;
  localparam logic [SEL_W-1:0] MS_VT2   = 4'd6;
  localparam logic [SEL_W-1:0] MS_CT2   = 4'd7;
  localparam logic [SEL_W-1:0] MS_RCH1  = 4'd8;
  localparam logic [SEL_W-1:0] MS_RCH2  = 4'd9;
  localparam logic [SEL_W-1:0] MS_RCH3  = 4'd10;

  typedef struct packed {
    logic              load;
    logic              mul_go;
    logic [SEL_W-1:0]  mul_sel;
    logic              div_init;
    logic              div_step;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              cord_init;
    logic              cord_step;
    logic [STEP_W-1:0] step_idx;
    logic              commit;
  } dzr_cmd_t;

  typedef struct packed {
    logic enabled;
    logic below;
  } dzr_sts_t;

  // arctan(2^-i) with pi = 2^20
  function automatic logic [ACC_W-1:0] atan_fine(input logic [STEP_W-1:0] i);
    logic [ACC_W-1:0] v;
    case (i)
      4'd0:    v = ACC_W'(262144);
      4'd1:    v = ACC_W'(154753);
      4'd2:    v = ACC_W'(81767);
      4'd3:    v = ACC_W'(41506);
      4'd4:    v = ACC_W'(20834);
      4'd5:    v = ACC_W'(10427);
      4'd6:    v = ACC_W'(5215);
      4'd7:    v = ACC_W'(2608);
      4'd8:    v = ACC_W'(1304);
      4'd9:    v = ACC_W'(652);
      4'd10:   v = ACC_W'(326);
      4'd11:   v = ACC_W'(163);
      4'd12:   v = ACC_W'(81);
      4'd13:   v = ACC_W'(41);
      4'd14:   v = ACC_W'(20);
      4'd15:   v = ACC_W'(10);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dzr_ctrl.sv
`default_nettype none
module dzr_ctrl #(
  parameter int CB = dzr_pkg::COMPONENT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire dzr_pkg::dzr_sts_t sts,
  output dzr_pkg::dzr_cmd_t      cmd
);
  import dzr_pkg::*;

  localparam int DW    = 2 * CB + 16;
  localparam int CNT_W = $clog2(DW);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DRAIN, S_CHECK, S_DIV, S_SQRT, S_CORD, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.mul_sel   = SEL_W'(cnt_r);
    cmd.step_idx  = STEP_W'(cnt_r);
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.enabled ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NMUL - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_CHECK;
      S_CHECK: begin
        cnt_nxt = '0;
        if (sts.below) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_init  = 1'b1;
          cmd.cord_init = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_init = (cnt_r == '0);
        cmd.sqrt_step = (cnt_r != '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_N)) begin
          cnt_nxt   = '0;
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_N - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dzr_datapath.sv
`default_nettype none
module dzr_datapath #(
  parameter int CB   = dzr_pkg::COMPONENT_BITS_DEF,
  parameter int IN_W = ((4 * CB + 32 + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [dzr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dzr_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic [IN_W-1:0]                   in_tdata,
  input  wire dzr_pkg::dzr_cmd_t                 cmd,
  output dzr_pkg::dzr_sts_t                      sts,
  output logic [dzr_pkg::OUT_W-1:0]              out_tdata,
  output logic [dzr_pkg::USER_W-1:0]             out_tuser
);
  import dzr_pkg::*;

  localparam int MW   = (CB > 25) ? CB : 25;
  localparam int PW   = 2 * MW;
  localparam int V2W  = 2 * CB;
  localparam int DW   = V2W + 16;
  localparam int CMPW = (V2W > REACH2_W) ? V2W : REACH2_W;
  localparam int QW   = (DW > REACH2_W) ? DW : REACH2_W;
  localparam int CW   = CB + 3;

  // configuration
  logic               en_r, fwd_r;
  logic [THR_W-1:0]   vt_r, ct_r;
  logic [CFG_W-1:0]   zset_r [NZONES];

  // sample
  logic signed [CB-1:0] vr_r, vi_r, ir_r, ii_r;
  logic [TIME_W-1:0]    now_r;

  // products
  logic signed [MW-1:0] a_op, b_op;
  logic signed [PW-1:0] prod_r;
  logic [SEL_W-1:0]     psel_r;
  logic                 pvld_r;
  logic [V2W-1:0]       v2_r, i2_r;
  logic signed [PW:0]   dot_r;
  logic [REACH2_W-1:0]  vt2_r, ct2_r;
  logic [REACH2_W-1:0]  rch2_r [NZONES];

  // divider and square root
  logic [DW-1:0]        nq_r;
  logic [V2W-1:0]       rem_r;
  logic [V2W:0]         dtrial;
  logic                 dge;
  logic [QW-1:0]        qext;
  logic [REACH2_W-1:0]  sq_r;
  logic [SQRT_N+1:0]    srem_r;
  logic [SQRT_N-1:0]    root_r;
  logic                 sat_r;
  logic [SQRT_N+3:0]    st, strial;
  logic                 sge;

  // two cordic lanes: voltage, current
  logic signed [CW-1:0]    cx_r [2], cy_r [2];
  logic signed [ACC_W-1:0] ca_r [2];
  logic                    cz_r [2];
  logic signed [CW-1:0]    cx_nxt [2], cy_nxt [2];
  logic signed [ACC_W-1:0] ca_nxt [2];
  logic signed [CW-1:0]    lx, ly, ldx, ldy;

  // result
  logic signed [DIFF_W-1:0] diff, diff_rnd;
  logic [ANG_W-1:0]         ang;
  logic [LIM_W-1:0]         abs_ang;
  logic [MAG_W-1:0]         mag;
  logic                     dir_ok;
  status_t                  status;
  logic [NZONES-1:0]        zin, trip;
  logic [TIME_W-1:0]        elapsed [NZONES];
  logic [LIM_W-1:0]         lim [NZONES];
  logic                     zone_act_r [NZONES];
  logic [TIME_W-1:0]        zone_start_r [NZONES];
  logic [OUT_W-1:0]         out_data_r;
  logic [USER_W-1:0]        out_user_r;

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  // operand select for the shared multiplier
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.mul_sel)
      MS_VR2:  begin a_op = MW'(vr_r); b_op = MW'(vr_r); end
      MS_VI2:  begin a_op = MW'(vi_r); b_op = MW'(vi_r); end
      MS_IR2:  begin a_op = MW'(ir_r); b_op = MW'(ir_r); end
      MS_II2:  begin a_op = MW'(ii_r); b_op = MW'(ii_r); end
      MS_DOTR: begin a_op = MW'(vr_r); b_op = MW'(ir_r); end
      MS_DOTI: begin a_op = MW'(vi_r); b_op = MW'(ii_r); end
      MS_VT2:  begin a_op = $signed(MW'(vt_r)); b_op = $signed(MW'(vt_r)); end
      MS_CT2:  begin a_op = $signed(MW'(ct_r)); b_op = $signed(MW'(ct_r)); end
      MS_RCH1: begin
        a_op = $signed(MW'(zset_r[0][REACH_W-1:0]));
        b_op = a_op;
      end
      MS_RCH2: begin
        a_op = $signed(MW'(zset_r[1][REACH_W-1:0]));
        b_op = a_op;
      end
      MS_RCH3: begin
        a_op = $signed(MW'(zset_r[2][REACH_W-1:0]));
        b_op = a_op;
      end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  assign sts.enabled = en_r;
  assign sts.below   = (i2_r == '0) || (CMPW'(v2_r) < CMPW'(vt2_r)) ||
                       (CMPW'(i2_r) < CMPW'(ct2_r));

  // restoring divider: v2 * 2^16 / i2, one quotient bit per step
  assign dtrial = {rem_r, nq_r[DW-1]};
  assign dge    = (dtrial >= {1'b0, i2_r});
  assign qext   = QW'(nq_r);

  // square root, one root bit per step
  assign st     = {srem_r, sq_r[REACH2_W-1 -: 2]};
  assign strial = (SQRT_N+4)'({root_r, 2'b01});
  assign sge    = (st >= strial);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lx  = cx_r[l];
      ly  = cy_r[l];
      ldx = ly >>> cmd.step_idx;
      ldy = lx >>> cmd.step_idx;
      if (!ly[CW-1]) begin
        cx_nxt[l] = lx + ldx;
        cy_nxt[l] = ly - ldy;
        ca_nxt[l] = ca_r[l] + $signed(atan_fine(cmd.step_idx));
      end else begin
        cx_nxt[l] = lx - ldx;
        cy_nxt[l] = ly + ldy;
        ca_nxt[l] = ca_r[l] - $signed(atan_fine(cmd.step_idx));
      end
    end
  end

  // angle and zone evaluation
  always_comb begin
    diff     = (cz_r[0] ? DIFF_W'(0) : DIFF_W'(ca_r[0])) -
               (cz_r[1] ? DIFF_W'(0) : DIFF_W'(ca_r[1]));
    diff_rnd = diff + DIFF_W'(16);
    ang      = diff_rnd[ANG_W+4:5];
    abs_ang  = ang[ANG_W-1] ? (LIM_W'(65536) - LIM_W'(ang)) : LIM_W'(ang);
    mag      = sat_r ? '1 : root_r;
    dir_ok   = fwd_r ? (dot_r > 0) : (dot_r < 0);
    if (!en_r) begin
      status = STS_DISABLED;
    end else if (sts.below) begin
      status = STS_BELOW;
    end else if (!dir_ok) begin
      status = STS_WRONG_DIR;
    end else begin
      status = STS_EVAL;
    end
    for (int z = 0; z < NZONES; z++) begin
      lim[z]     = zset_r[z][ZS_LIM_LO +: LIM_W];
      zin[z]     = zset_r[z][ZS_EN] &&
                   ((QW'(rch2_r[z]) > qext) ||
                    ((QW'(rch2_r[z]) == qext) && (rem_r == '0))) &&
                   ((abs_ang <= lim[z]) ||
                    ((LIM_W+1)'(abs_ang) + (LIM_W+1)'(lim[z]) >= (LIM_W+1)'(65536)));
      elapsed[z] = zone_act_r[z] ? (now_r - zone_start_r[z]) : '0;
      trip[z]    = (status == STS_EVAL) && zin[z] &&
                   (elapsed[z] >= TIME_W'(zset_r[z][ZS_DELAY_LO +: DELAY_W]));
    end
  end

  // configuration and zone state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b0;
      fwd_r <= 1'b1;
      vt_r  <= '0;
      ct_r  <= '0;
      for (int z = 0; z < NZONES; z++) begin
        zset_r[z]       <= '0;
        zone_act_r[z]   <= 1'b0;
        zone_start_r[z] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE: begin
            en_r <= cfg_data[0];
            if (!cfg_data[0]) begin
              for (int z = 0; z < NZONES; z++) zone_act_r[z] <= 1'b0;
            end
          end
          REG_DIRECTION: fwd_r     <= cfg_data[0];
          REG_VTHR:      vt_r      <= cfg_data[THR_W-1:0];
          REG_CTHR:      ct_r      <= cfg_data[THR_W-1:0];
          REG_ZONE1:     zset_r[0] <= cfg_data;
          REG_ZONE2:     zset_r[1] <= cfg_data;
          REG_ZONE3:     zset_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit && status != STS_DISABLED) begin
        for (int z = 0; z < NZONES; z++) begin
          if (status == STS_EVAL && zin[z]) begin
            if (!zone_act_r[z]) begin
              zone_act_r[z]   <= 1'b1;
              zone_start_r[z] <= now_r;
            end
          end else begin
            zone_act_r[z] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.mul_go;
    end
  end

  // payload, product, divider, square root, cordic and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vr_r  <= in_tdata[0 +: CB];
      vi_r  <= in_tdata[CB +: CB];
      ir_r  <= in_tdata[2*CB +: CB];
      ii_r  <= in_tdata[3*CB +: CB];
      now_r <= in_tdata[4*CB +: TIME_W];
    end
    prod_r <= a_op * b_op;
    psel_r <= cmd.mul_sel;
    if (pvld_r) begin
      case (psel_r)
        MS_VR2:  v2_r  <= V2W'(prod_r);
        MS_VI2:  v2_r  <= v2_r + V2W'(prod_r);
        MS_IR2:  i2_r  <= V2W'(prod_r);
        MS_II2:  i2_r  <= i2_r + V2W'(prod_r);
        MS_DOTR: dot_r <= (PW+1)'(prod_r);
        MS_DOTI: dot_r <= dot_r + (PW+1)'(prod_r);
        MS_VT2:  vt2_r <= REACH2_W'(prod_r);
        MS_CT2:  ct2_r <= REACH2_W'(prod_r);
        MS_RCH1: rch2_r[0] <= REACH2_W'(prod_r);
        MS_RCH2: rch2_r[1] <= REACH2_W'(prod_r);
        MS_RCH3: rch2_r[2] <= REACH2_W'(prod_r);
        default: ;
      endcase
    end
    if (cmd.div_init) begin
      nq_r  <= {v2_r, 16'b0};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      nq_r  <= {nq_r[DW-2:0], dge};
      rem_r <= dge ? V2W'(dtrial - {1'b0, i2_r}) : V2W'(dtrial);
    end
    if (cmd.sqrt_init) begin
      sat_r  <= (qext >> REACH2_W) != '0;
      sq_r   <= qext[REACH2_W-1:0];
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      sq_r   <= {sq_r[REACH2_W-3:0], 2'b00};
      srem_r <= sge ? (SQRT_N+2)'(st - strial) : (SQRT_N+2)'(st);
      root_r <= {root_r[SQRT_N-2:0], sge};
    end
    if (cmd.cord_init) begin
      // negative x: rotate by pi first
      cz_r[0] <= (vr_r == '0) && (vi_r == '0);
      cz_r[1] <= (ir_r == '0) && (ii_r == '0);
      cx_r[0] <= vr_r[CB-1] ? -CW'(vr_r) : CW'(vr_r);
      cy_r[0] <= vr_r[CB-1] ? -CW'(vi_r) : CW'(vi_r);
      ca_r[0] <= vr_r[CB-1] ? $signed(ANG_PI_FINE) : '0;
      cx_r[1] <= ir_r[CB-1] ? -CW'(ir_r) : CW'(ir_r);
      cy_r[1] <= ir_r[CB-1] ? -CW'(ii_r) : CW'(ii_r);
      ca_r[1] <= ir_r[CB-1] ? $signed(ANG_PI_FINE) : '0;
    end else if (cmd.cord_step) begin
      for (int l = 0; l < 2; l++) begin
        cx_r[l] <= cx_nxt[l];
        cy_r[l] <= cy_nxt[l];
        ca_r[l] <= ca_nxt[l];
      end
    end
    if (cmd.commit) begin
      out_user_r <= status;
      if (status == STS_DISABLED || status == STS_BELOW) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= OUT_W'({trip, ang, mag});
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/distance_zone_relay_core.sv
`default_nettype none
// channel  direction  handshake             payload
// in       slave      in_tvalid/in_tready   in_tdata: v re, v im, i re, i im, now_ms
// out      master     out_tvalid/out_tready out_tdata: magnitude, angle, trips; out_tuser
// cfg      slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one word at a time; an evaluated word passes through the bit-serial divider
// (2*COMPONENT_BITS+16 steps), the 24-step square root and the 16-step cordic.
// disabled words skip all of these, and below-threshold words stop after the
// multiplier products.
// a finished word waits in the output register while the next is computed.
// rst_n is synchronous; configuration resets to disabled, forward, zero thresholds and zero zones.
module distance_zone_relay_core #(
  parameter int COMPONENT_BITS = dzr_pkg::COMPONENT_BITS_DEF,
  parameter int IN_W = ((4 * COMPONENT_BITS + 32 + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // voltage_real, voltage_imag, current_real, current_imag, now_ms, zero pad
  input  wire logic [IN_W-1:0]               in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // impedance_magnitude, impedance_angle, zone1_trip, zone2_trip, zone3_trip, zero pad
  output logic [dzr_pkg::OUT_W-1:0]          out_tdata,
  // status
  output logic [dzr_pkg::USER_W-1:0]         out_tuser,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dzr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dzr_pkg::CFG_W-1:0]     cfg_data
);
  import dzr_pkg::*;

  dzr_cmd_t cmd;
  dzr_sts_t sts;

  assign cfg_ready = 1'b1;

  dzr_ctrl #(.CB(COMPONENT_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dzr_datapath #(.CB(COMPONENT_BITS), .IN_W(IN_W)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STS_DISABLED || out_tuser == STS_BELOW)
      |-> out_tdata == '0)
    else $error("nonzero result without evaluation");

  a_trip_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STS_EVAL |-> out_tdata[OD_TRIP_LO +: NZONES] == '0)
    else $error("trip outside zone evaluation");
`endif

endmodule
`default_nettype wire

// File: dv/tb_distance_zone_relay_core.sv
`timescale 1ns / 100ps
module tb_distance_zone_relay_core;
  import dzr_pkg::*;

  localparam int CB   = 24;
  localparam int IN_W = ((4 * CB + 32 + 7) / 8) * 8;
  localparam longint ATAN_FINE [16] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215,
                                        2608, 1304, 652, 326, 163, 81, 41, 20, 10};
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [ANG_W-1:0] ang;
    logic [2:0]       trip;
    status_t          status;
  } relay_result_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  distance_zone_relay_core #(.COMPONENT_BITS(CB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // relay settings and zone timers as the block should hold them
  logic             enabled, dir_fwd;
  logic [THR_W-1:0] v_thr, c_thr;
  logic [CFG_W-1:0] zone_cfg [3];
  logic             zone_on [3];
  logic [31:0]      zone_t0 [3];

  relay_result_t pending_results [$];
  int  errors;
  int  burst_left;
  bit  no_gaps;
  int  long_hold_req;
  int  hold_count;
  int  stall_mode;
  int  stall_left;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint fine_angle(longint x, longint y);
    longint acc, dx, dy;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 1048576;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += ATAN_FINE[i];
      end else begin
        x -= dx; y += dy; acc -= ATAN_FINE[i];
      end
    end
    return acc;
  endfunction

  task automatic evaluate_relay(input logic signed [CB-1:0] vr, vi, ir, ii,
                                input logic [31:0] now, output relay_result_t r);
    longint a, b, diff, abs_ang, lim;
    logic [127:0] v2, i2, c, reach;
    logic [MAG_W-1:0] mag;
    logic [ANG_W-1:0] ang;
    logic fwd, dir_ok, in_zone;
    r = '0;
    r.status = STS_DISABLED;
    if (!enabled) return;
    v2 = 128'(longint'(vr) * vr + longint'(vi) * vi);
    i2 = 128'(longint'(ir) * ir + longint'(ii) * ii);
    if (i2 == 0 || v2 < 128'(v_thr) * v_thr || i2 < 128'(c_thr) * c_thr) begin
      for (int z = 0; z < 3; z++) zone_on[z] = 0;
      r.status = STS_BELOW;
      return;
    end
    mag = '0;
    for (int k = 23; k >= 0; k--) begin
      c = 128'(mag | (24'd1 << k));
      if (c * c * i2 <= (v2 << 16)) mag = c[23:0];
    end
    diff = fine_angle(vr, vi) - fine_angle(ir, ii);
    ang = 16'((diff + 16) >>> 5);
    r.mag = mag;
    r.ang = ang;
    a = longint'(vr) * ir;
    b = longint'(vi) * ii;
    fwd = a > -b;
    dir_ok = dir_fwd ? fwd : (a < -b);
    if (!dir_ok) begin
      for (int z = 0; z < 3; z++) zone_on[z] = 0;
      r.status = STS_WRONG_DIR;
      return;
    end
    abs_ang = ang[15] ? 65536 - longint'(ang) : longint'(ang);
    for (int z = 0; z < 3; z++) begin
      reach = 128'(zone_cfg[z][REACH_W-1:0]);
      lim = longint'(zone_cfg[z][ZS_DELAY_LO-1:ZS_LIM_LO]);
      in_zone = zone_cfg[z][ZS_EN] && (reach * reach * i2 >= (v2 << 16)) &&
                (abs_ang <= lim || abs_ang + lim >= 65536);
      if (in_zone) begin
        if (!zone_on[z]) begin
          zone_on[z] = 1;
          zone_t0[z] = now;
        end
        if (32'(now - zone_t0[z]) >= 32'(zone_cfg[z][ZS_EN-1:ZS_DELAY_LO])) r.trip[z] = 1;
      end else begin
        zone_on[z] = 0;
      end
    end
    r.status = STS_EVAL;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLE: begin
        enabled = val[0];
        if (!val[0]) for (int z = 0; z < 3; z++) zone_on[z] = 0;
      end
      REG_DIRECTION: dir_fwd = val[0];
      REG_VTHR:      v_thr = val[THR_W-1:0];
      REG_CTHR:      c_thr = val[THR_W-1:0];
      REG_ZONE1:     zone_cfg[0] = val;
      REG_ZONE2:     zone_cfg[1] = val;
      REG_ZONE3:     zone_cfg[2] = val;
      default: ;
    endcase
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] zone_word(input logic en, input logic [15:0] delay,
                                                  input logic [16:0] lim,
                                                  input logic [23:0] reach);
    return {en, delay, lim, reach};
  endfunction

  task automatic send_word(input logic signed [CB-1:0] vr, vi, ir, ii,
                           input logic [31:0] now);
    relay_result_t r;
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        if (gap > 0) begin
          in_tvalid <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_tvalid <= 1;
    in_tdata  <= {32'(now), ii, ir, vi, vr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    evaluate_relay(vr, vi, ir, ii, now, r);
    pending_results.push_back(r);
  endtask

  task automatic drain_results;
    in_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // receiver: checks each word, stalls on a changing pattern, long hold on request
  always @(posedge clk) begin
    relay_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mag    = out_tdata[MAG_W-1:0];
      got.ang    = out_tdata[OD_TRIP_LO-1:OD_ANG_LO];
      got.trip   = out_tdata[OD_TRIP_LO+2:OD_TRIP_LO];
      got.status = status_t'(out_tuser);
      if (pending_results.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.mag != want.mag) begin
          $error("impedance_magnitude exp %0d got %0d", want.mag, got.mag); errors++;
        end
        if (got.ang != want.ang) begin
          $error("impedance_angle exp %0d got %0d", want.ang, got.ang); errors++;
        end
        for (int z = 0; z < 3; z++)
          if (got.trip[z] != want.trip[z]) begin
            $error("zone%0d_trip exp %0d got %0d", z + 1, want.trip[z], got.trip[z]);
            errors++;
          end
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
      end
    end
    if (long_hold_req > 0) begin
      hold_count = long_hold_req;
      long_hold_req = 0;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 600);
    end else begin
      stall_left--;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_tready <= 0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  function automatic logic signed [CB-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'sh7fffff;
      2: return 24'sh800000;
      3: return 24'($signed(10'($urandom)));
      default: return 24'($signed(17'($urandom)));
    endcase
  endfunction

  function automatic logic signed [CB-1:0] clamp(input longint v);
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return 24'(v);
  endfunction

  task automatic test_disabled_after_reset;
    send_word(24'sh123456, -24'sd5, 24'sd7, 24'sh7fffff, 32'd1);
    send_word(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000, 32'hffffffff);
    send_word('0, '0, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_directed_cases;
    write_reg(REG_ENABLE, CFG_W'(1'b1));
    write_reg(REG_ZONE1, zone_word(1'b1, 16'd0, 17'd131071, 24'hffffff));
    write_reg(REG_ZONE2, zone_word(1'b1, 16'd5, 17'd0, 24'd4096));
    write_reg(REG_ZONE3, zone_word(1'b1, 16'hffff, 17'd16384, 24'd1000));
    send_word(24'sd1000, 24'sd0, 24'sd100, 24'sd0, 32'd0);      // pure resistive, zero angle
    send_word(24'sd1000, 24'sd0, 24'sd100, 24'sd0, 32'd10);     // zone two delay met
    send_word(24'sd1000, 24'sd5, 24'sd0, 24'sd0, 32'd11);       // zero current
    send_word(24'sd0, 24'sd0, 24'sd5, 24'sd3, 32'd12);          // zero voltage, re exactly 0
    send_word(24'sd1, 24'sd0, 24'sd0, 24'sd1, 32'd13);          // re(z) exactly zero
    send_word(-24'sd1000, 24'sd0, 24'sd100, 24'sd0, 32'd14);    // reverse
    send_word(24'sh7fffff, 24'sh7fffff, 24'sd1, 24'sd0, 32'd15); // saturating magnitude
    send_word(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 32'd16);
    send_word(24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 32'd17);
    send_word(-24'sd3, -24'sd4, -24'sd1, 24'sd0, 32'hfffffff0);
    send_word(-24'sd3, -24'sd4, -24'sd1, 24'sd0, 32'h00000004); // timestamp wrap
    drain_results();
    write_reg(REG_VTHR, CFG_W'(24'hffffff));
    write_reg(REG_CTHR, CFG_W'(24'd0));
    send_word(24'sh7fffff, 24'sh7fffff, 24'sd1, 24'sd1, 32'd20); // below voltage threshold
    drain_results();
    write_reg(REG_VTHR, CFG_W'(24'd0));
    write_reg(REG_CTHR, CFG_W'(24'hffffff));
    send_word(24'sd1000, 24'sd0, 24'sh7fffff, 24'sh7fffff, 32'd21);
    drain_results();
    write_reg(REG_CTHR, CFG_W'(24'd0));
    write_reg(REG_DIRECTION, CFG_W'(1'b0));
    send_word(-24'sd1000, 24'sd20, 24'sd100, 24'sd0, 32'd22);
    send_word(24'sd1000, 24'sd20, 24'sd100, 24'sd0, 32'd23);
    send_word(24'sd1, 24'sd0, 24'sd0, 24'sd1, 32'd24);
    drain_results();
    write_reg(REG_UNUSED, '1);
    write_reg(REG_DIRECTION, CFG_W'(1'b1));
    write_reg(REG_ENABLE, CFG_W'(1'b0));
    send_word(24'sd1000, 24'sd0, 24'sd100, 24'sd0, 32'd25);
    drain_results();
  endtask

  task automatic random_settings;
    write_reg(REG_ENABLE, CFG_W'($urandom_range(0, 9) != 0));
    write_reg(REG_DIRECTION, CFG_W'($urandom_range(0, 3) != 0));
    write_reg(REG_VTHR, CFG_W'(($urandom_range(0, 2) == 0) ?
                               24'($urandom_range(0, 3000)) : 24'd0));
    write_reg(REG_CTHR, CFG_W'(($urandom_range(0, 2) == 0) ?
                               24'($urandom_range(0, 300)) : 24'd0));
    for (int z = 0; z < 3; z++)
      write_reg(REG_ZONE1 + 3'(z), zone_word(
        ($urandom_range(0, 5) != 0),
        ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)),
        ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 40000)),
        ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5000))));
  endtask

  // fault-like episodes: a steady impedance with small noise while time runs on, mixed with random words
  task automatic test_random_episodes(input int n_items);
    int sent, len;
    longint zr, zi, ir, ii;
    logic [31:0] now;
    sent = 0;
    while (sent < n_items) begin
      drain_results();
      random_settings();
      for (int e = 0; e < 6 && sent < n_items; e++) begin
        len = $urandom_range(1, 40);
        now = ($urandom_range(0, 3) == 0) ? 32'hffffffff - $urandom_range(0, 300) : $urandom;
        zr = $signed($urandom_range(0, 128)) - 64;
        zi = $signed($urandom_range(0, 128)) - 64;
        ir = $signed($urandom_range(0, 131072)) - 65536;
        ii = $signed($urandom_range(0, 131072)) - 65536;
        for (int k = 0; k < len && sent < n_items; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp(), $urandom);
          else
            send_word(clamp(((ir * zr - ii * zi) >>> 4) + int'($urandom_range(0, 6)) - 3),
                      clamp(((ir * zi + ii * zr) >>> 4) + int'($urandom_range(0, 6)) - 3),
                      clamp(ir + int'($urandom_range(0, 4)) - 2),
                      clamp(ii + int'($urandom_range(0, 4)) - 2), now);
          now += $urandom_range(0, 40);
          sent++;
        end
      end
    end
    drain_results();
  endtask

  task automatic test_output_backpressure;
    write_reg(REG_ENABLE, CFG_W'(1'b1));
    write_reg(REG_ZONE1, zone_word(1'b1, 16'd3, 17'd65536, 24'd50000));
    no_gaps = 1;
    long_hold_req = 2000;
    for (int k = 0; k < 40; k++)
      send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 32'(k * 2));
    no_gaps = 0;
    drain_results();
  endtask

  initial begin
    errors = 0; burst_left = 0; no_gaps = 0; long_hold_req = 0;
    hold_count = 0; stall_mode = 0; stall_left = 0;
    enabled = 0; dir_fwd = 1; v_thr = '0; c_thr = '0;
    for (int z = 0; z < 3; z++) begin
      zone_cfg[z] = '0; zone_on[z] = 0; zone_t0[z] = '0;
    end
    rst_n <= 0;
    in_tvalid <= 0; in_tdata <= '0;
    out_tready <= 0;
    cfg_valid <= 0; cfg_index <= '0; cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_disabled_after_reset();
    test_directed_cases();
    test_output_backpressure();
    test_random_episodes(1500);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dzr_pkg.sv
rtl/core/dzr_ctrl.sv
rtl/core/dzr_datapath.sv
rtl/core/distance_zone_relay_core.sv
dv/tb_distance_zone_relay_core.sv
